FILE: hw/rtl/ces_pkg.sv
// Shared constants, types and saturating arithmetic helpers for the CELP synthesis core.
package ces_pkg;

  localparam int SUB_LEN = 40;
  localparam int ORDER   = 10;
  localparam int NCOEF   = ORDER + 1;
  localparam int CNT_W   = $clog2(SUB_LEN + 1);
  localparam int AW      = $clog2(SUB_LEN);

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_GAINS = 2'd1;
  localparam logic [1:0] CMD_PAIR  = 2'd2;

  localparam logic signed [6:0] CODE_SHR_BASE = 7'sd13;
  localparam logic [4:0]        SYN_SHL       = 5'd3;
  localparam logic [4:0]        EXC_SHL       = 5'd1;
  localparam int                RESCALE_SHR   = 2;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic              ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic              ovf;
    logic signed [15:0] val;
  } sat16_t;

  function automatic sat_t sat33(input logic signed [32:0] x);
    sat_t r;
    r.ovf = (x[32] != x[31]);
    r.val = r.ovf ? (x[32] ? MIN32 : MAX32) : x[31:0];
    return r;
  endfunction

  // Saturating left shift by up to 19 places.
  function automatic sat_t shl_sat(input logic signed [31:0] x, input logic [4:0] k);
    logic signed [50:0] e;
    sat_t r;
    e = {{19{x[31]}}, x} <<< k;
    r.ovf = (e[50:31] != {20{e[31]}});
    r.val = r.ovf ? (x[31] ? MIN32 : MAX32) : e[31:0];
    return r;
  endfunction

  function automatic sat16_t round16(input logic signed [31:0] x);
    sat_t s;
    sat16_t r;
    s = sat33({x[31], x} + 33'sd32768);
    r.ovf = s.ovf;
    r.val = s.val[31:16];
    return r;
  endfunction

endpackage

FILE: hw/rtl/ces_ram.sv
// Generic single-write, single-read memory with registered read data.
module ces_ram #(
  parameter int DEPTH = 40,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ces_mac.sv
// Shared saturating multiplier with optional multiply-subtract against an accumulator.
module ces_mac (
  input  logic signed [15:0] mul_a,
  input  logic signed [15:0] mul_b,
  input  logic signed [31:0] acc,
  input  logic               msu,
  output logic signed [31:0] res,
  output logic               ovf
);

  logic signed [31:0] prod;
  logic signed [31:0] m;
  logic               both_min;
  ces_pkg::sat_t      diff;

  always_comb begin
    prod     = mul_a * mul_b;
    both_min = (mul_a == 16'sh8000) && (mul_b == 16'sh8000);
    m        = both_min ? ces_pkg::MAX32 : (prod <<< 1);
    diff     = ces_pkg::sat33({acc[31], acc} - {m[31], m});
    res      = msu ? diff.val : m;
    ovf      = both_min | (msu & diff.ovf);
  end

endmodule

FILE: hw/rtl/celp_excitation_and_synthesis_filter_core.sv
// Top level: command decode, excitation build, synthesis filter sequencer and output stage.
//
// Input words carry a command: load one predictor coefficient, load the gains,
// or deliver one adaptive/fixed codebook sample pair. Coefficient and gain
// words are stored directly; a sample pair is built in steps (pitch product
// and code product on the shared multiplier, then combine and round).
// The fortieth pair starts the filter: each output sample is built from one
// memory read, one multiply, ten multiply-subtracts on the shared MAC and
// one shift and round; a pass that saturates anywhere is redone once on the
// excitation shifted right by two.
// The forty results then leave through an output register; the next word is
// loaded only after the receiver has taken the last one. out_last marks the
// final word and out_rescaled marks every word of a repeated pass.
// in_stall is high whenever the sequencer is busy. A stalled result word
// holds its value until taken. Reset clears coefficients, gains, filter
// memory and the sample count; the sample memories need no clearing.
module celp_excitation_and_synthesis_filter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic signed [15:0] in_pitch_gain,
  input  logic signed [15:0] in_code_gain_mantissa,
  input  logic signed [5:0]  in_code_gain_exponent,
  input  logic signed [15:0] in_pitch_sample,
  input  logic signed [15:0] in_code_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_speech_sample,
  output logic               out_last,
  output logic               out_rescaled
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EX1  = 4'd1;
  localparam logic [3:0] S_EX2  = 4'd2;
  localparam logic [3:0] S_EX3  = 4'd3;
  localparam logic [3:0] S_FRD  = 4'd4;
  localparam logic [3:0] S_FM0  = 4'd5;
  localparam logic [3:0] S_FMAC = 4'd6;
  localparam logic [3:0] S_FFIN = 4'd7;
  localparam logic [3:0] S_FEND = 4'd8;
  localparam logic [3:0] S_ERD  = 4'd9;
  localparam logic [3:0] S_ELD  = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic signed [15:0] coef_r [ces_pkg::NCOEF];
  logic signed [15:0] hist_r [ces_pkg::ORDER];
  logic signed [15:0] fmem_r [ces_pkg::ORDER];
  logic signed [15:0] gp_r, gm_r, pv_r, cv_r;
  logic signed [5:0]  ge_r;
  logic signed [31:0] lp_r, lc_r, acc_r;
  logic [ces_pkg::CNT_W-1:0] cnt_r, n_r, e_r;
  logic [3:0] i_r;
  logic ovf_r, pass2_r;
  logic out_valid_r, out_last_r, out_resc_r;
  logic signed [15:0] out_data_r;

  logic in_acc, out_acc;
  logic signed [15:0] mac_a, mac_b, exc_q, out_q, x_in;
  logic signed [31:0] mac_res;
  logic mac_msu, mac_ovf;
  logic signed [6:0] sh_n, sh_neg;
  logic signed [31:0] code_l;
  ces_pkg::sat_t   sum_s, exc_sh, syn_sh, code_up;
  ces_pkg::sat16_t exc_rnd, syn_rnd;
  logic [3:0] hidx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_speech_sample = out_data_r;
  assign out_last     = out_last_r;
  assign out_rescaled = out_resc_r;

  assign hidx = i_r - 4'd1;
  assign x_in = pass2_r ? (exc_q >>> ces_pkg::RESCALE_SHR) : exc_q;

  always_comb begin
    mac_a   = gp_r;
    mac_b   = pv_r;
    mac_msu = 1'b0;
    unique case (state_r)
      S_EX2: begin
        mac_a = gm_r;
        mac_b = cv_r;
      end
      S_FM0: begin
        mac_a = x_in;
        mac_b = coef_r[0];
      end
      S_FMAC: begin
        mac_a   = coef_r[i_r];
        mac_b   = hist_r[hidx];
        mac_msu = 1'b1;
      end
      default: begin
        mac_a = gp_r;
        mac_b = pv_r;
      end
    endcase
  end

  ces_mac u_mac (
    .mul_a (mac_a),
    .mul_b (mac_b),
    .acc   (acc_r),
    .msu   (mac_msu),
    .res   (mac_res),
    .ovf   (mac_ovf)
  );

  // Fixed codebook gain scaling: right by 13 - exponent, left when negative.
  always_comb begin
    sh_n    = ces_pkg::CODE_SHR_BASE - {ge_r[5], ge_r};
    sh_neg  = -sh_n;
    code_up = ces_pkg::shl_sat(mac_res, sh_neg[4:0]);
    if (gm_r == 16'sd0) begin
      code_l = 32'sd0;
    end else if (sh_n >= 7'sd31) begin
      code_l = {32{mac_res[31]}};
    end else if (sh_n >= 7'sd0) begin
      code_l = mac_res >>> sh_n[4:0];
    end else begin
      code_l = code_up.val;
    end
    sum_s   = ces_pkg::sat33({lp_r[31], lp_r} + {lc_r[31], lc_r});
    exc_sh  = ces_pkg::shl_sat(sum_s.val, ces_pkg::EXC_SHL);
    exc_rnd = ces_pkg::round16(exc_sh.val);
    syn_sh  = ces_pkg::shl_sat(acc_r, ces_pkg::SYN_SHL);
    syn_rnd = ces_pkg::round16(syn_sh.val);
  end

  ces_ram #(.DEPTH(ces_pkg::SUB_LEN), .WIDTH(16)) u_exc_ram (
    .clk   (clk),
    .we    (state_r == S_EX3),
    .waddr (cnt_r[ces_pkg::AW-1:0]),
    .wdata (exc_rnd.val),
    .raddr (n_r[ces_pkg::AW-1:0]),
    .rdata (exc_q)
  );

  ces_ram #(.DEPTH(ces_pkg::SUB_LEN), .WIDTH(16)) u_out_ram (
    .clk   (clk),
    .we    (state_r == S_FFIN),
    .waddr (n_r[ces_pkg::AW-1:0]),
    .wdata (syn_rnd.val),
    .raddr (e_r[ces_pkg::AW-1:0]),
    .rdata (out_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_cmd == ces_pkg::CMD_PAIR) state_nxt = S_EX1;
      S_EX1:  state_nxt = S_EX2;
      S_EX2:  state_nxt = S_EX3;
      S_EX3:  state_nxt = (cnt_r == ces_pkg::CNT_W'(ces_pkg::SUB_LEN - 1)) ? S_FRD : S_IDLE;
      S_FRD:  state_nxt = S_FM0;
      S_FM0:  state_nxt = S_FMAC;
      S_FMAC: if (i_r == 4'(ces_pkg::ORDER)) state_nxt = S_FFIN;
      S_FFIN: state_nxt = (n_r == ces_pkg::CNT_W'(ces_pkg::SUB_LEN - 1)) ? S_FEND : S_FRD;
      S_FEND: state_nxt = (!pass2_r && ovf_r) ? S_FRD : S_ERD;
      S_ERD:  if (!out_valid_r) state_nxt = S_ELD;
      S_ELD:  state_nxt = (e_r == ces_pkg::CNT_W'(ces_pkg::SUB_LEN - 1)) ? S_IDLE : S_ERD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gp_r        <= '0;
      gm_r        <= '0;
      ge_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ces_pkg::NCOEF; k++) coef_r[k] <= '0;
      for (int k = 0; k < ces_pkg::ORDER; k++) fmem_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == ces_pkg::CMD_COEF) begin
              if (in_coef_index <= 4'(ces_pkg::ORDER)) coef_r[in_coef_index] <= in_coef_value;
            end else if (in_cmd == ces_pkg::CMD_GAINS) begin
              gp_r <= in_pitch_gain;
              gm_r <= in_code_gain_mantissa;
              ge_r <= in_code_gain_exponent;
            end
          end
        end
        S_EX3: begin
          if (cnt_r == ces_pkg::CNT_W'(ces_pkg::SUB_LEN - 1)) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FEND: begin
          if (pass2_r || !ovf_r) begin
            for (int k = 0; k < ces_pkg::ORDER; k++) fmem_r[k] <= hist_r[k];
          end
        end
        S_ELD: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers; the sequencer above guarantees they are written before use.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pv_r <= in_pitch_sample;
      cv_r <= in_code_sample;
    end
    case (state_r)
      S_EX1: lp_r <= mac_res;
      S_EX2: lc_r <= code_l;
      S_EX3: begin
        n_r     <= '0;
        ovf_r   <= 1'b0;
        pass2_r <= 1'b0;
        for (int k = 0; k < ces_pkg::ORDER; k++) hist_r[k] <= fmem_r[k];
      end
      S_FM0: begin
        acc_r <= mac_res;
        ovf_r <= ovf_r | mac_ovf;
        i_r   <= 4'd1;
      end
      S_FMAC: begin
        acc_r <= mac_res;
        ovf_r <= ovf_r | mac_ovf;
        i_r   <= i_r + 4'd1;
      end
      S_FFIN: begin
        ovf_r     <= ovf_r | syn_sh.ovf | syn_rnd.ovf;
        hist_r[0] <= syn_rnd.val;
        for (int k = 1; k < ces_pkg::ORDER; k++) hist_r[k] <= hist_r[k-1];
        n_r <= n_r + 1'b1;
      end
      S_FEND: begin
        e_r <= '0;
        if (!pass2_r && ovf_r) begin
          pass2_r <= 1'b1;
          n_r     <= '0;
          for (int k = 0; k < ces_pkg::ORDER; k++) hist_r[k] <= fmem_r[k];
        end
      end
      S_ELD: begin
        out_data_r <= out_q;
        out_last_r <= (e_r == ces_pkg::CNT_W'(ces_pkg::SUB_LEN - 1));
        out_resc_r <= pass2_r;
        e_r        <= e_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the CELP excitation and synthesis filter core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 17;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    shortint speech;
    bit      last;
    bit      resc;
  } speech_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [3:0] in_coef_index = '0;
  logic signed [15:0] in_coef_value = '0;
  logic signed [15:0] in_pitch_gain = '0;
  logic signed [15:0] in_code_gain_mantissa = '0;
  logic signed [5:0] in_code_gain_exponent = '0;
  logic signed [15:0] in_pitch_sample = '0;
  logic signed [15:0] in_code_sample = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] out_speech_sample;
  logic out_last;
  logic out_rescaled;

  celp_excitation_and_synthesis_filter_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  shortint coefs[ces_pkg::NCOEF];
  shortint pitch_gain_q, code_mant_q;
  int code_exp_q;
  shortint excitation[ces_pkg::SUB_LEN];
  shortint syn_memory[ces_pkg::ORDER];
  int pair_count;
  bit sat_hit;
  speech_word_t speech_expected[$];

  int errors = 0;
  bit calm = 1'b0;
  bit hold = 1'b0;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) begin
      sat_hit = 1'b1;
      return 32'h7fffffff;
    end
    if (x < -64'sd2147483648) begin
      sat_hit = 1'b1;
      return 32'h80000000;
    end
    return int'(x);
  endfunction

  function automatic int mult16(shortint a, shortint b);
    return sat32(longint'(a) * longint'(b) * 2);
  endfunction

  function automatic int shr_pos(int x, int n);
    if (n >= 31) return (x < 0) ? -1 : 0;
    return x >>> n;
  endfunction

  function automatic int shl_sat(int x, int n);
    if (n <= 0) return shr_pos(x, -n);
    for (int k = 0; k < n; k++) begin
      if (x > 32'sh3fffffff) begin
        sat_hit = 1'b1;
        return 32'h7fffffff;
      end
      if (x < -32'sh40000000) begin
        sat_hit = 1'b1;
        return 32'h80000000;
      end
      x = x * 2;
    end
    return x;
  endfunction

  function automatic shortint round_hi(int x);
    int t;
    t = shr_pos(sat32(longint'(x) + 32768), 16);
    return shortint'(t[15:0]);
  endfunction

  function automatic void filter_subframe(bit scaled,
                                          ref shortint w[ces_pkg::SUB_LEN + ces_pkg::ORDER]);
    shortint x;
    int acc;
    for (int i = 0; i < ces_pkg::ORDER; i++) w[i] = syn_memory[i];
    for (int n = 0; n < ces_pkg::SUB_LEN; n++) begin
      x = excitation[n];
      if (scaled) x = shortint'(shr_pos(x, 2));
      acc = mult16(x, coefs[0]);
      for (int i = 1; i <= ces_pkg::ORDER; i++)
        acc = sat32(longint'(acc) - mult16(coefs[i], w[ces_pkg::ORDER + n - i]));
      w[ces_pkg::ORDER + n] = round_hi(shl_sat(acc, 3));
    end
  endfunction

  function automatic void predict_word(logic [1:0] c, logic [3:0] idx, shortint cv,
                                       shortint pg, shortint gm, logic signed [5:0] ge,
                                       shortint ps, shortint cs);
    int l_pitch, l_code, sh;
    bit resc;
    shortint w[ces_pkg::SUB_LEN + ces_pkg::ORDER];
    speech_word_t sw;
    if (c == ces_pkg::CMD_COEF) begin
      if (idx <= ces_pkg::ORDER) coefs[idx] = cv;
      return;
    end
    if (c == ces_pkg::CMD_GAINS) begin
      pitch_gain_q = pg;
      code_mant_q = gm;
      code_exp_q = int'(ge);
      return;
    end
    if (c != ces_pkg::CMD_PAIR) return;
    l_pitch = mult16(pitch_gain_q, ps);
    l_code = 0;
    if (code_mant_q != 0) begin
      sh = 13 - code_exp_q;
      l_code = mult16(code_mant_q, cs);
      l_code = (sh < 0) ? shl_sat(l_code, -sh) : shr_pos(l_code, sh);
    end
    excitation[pair_count] = round_hi(shl_sat(sat32(longint'(l_pitch) + l_code), 1));
    pair_count++;
    if (pair_count < ces_pkg::SUB_LEN) return;
    pair_count = 0;
    sat_hit = 1'b0;
    filter_subframe(1'b0, w);
    resc = sat_hit;
    if (resc) filter_subframe(1'b1, w);
    for (int n = 0; n < ces_pkg::ORDER; n++) syn_memory[n] = w[ces_pkg::SUB_LEN + n];
    for (int n = 0; n < ces_pkg::SUB_LEN; n++) begin
      sw.speech = w[ces_pkg::ORDER + n];
      sw.last = (n == ces_pkg::SUB_LEN - 1);
      sw.resc = resc;
      speech_expected.push_back(sw);
    end
  endfunction

  // Sends one word; valid stays high on return so back-to-back words need no gap.
  task automatic send_word(logic [1:0] c, logic [3:0] idx, shortint cv, shortint pg,
                           shortint gm, logic signed [5:0] ge, shortint ps, shortint cs);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_coef_index <= idx;
    in_coef_value <= cv;
    in_pitch_gain <= pg;
    in_code_gain_mantissa <= gm;
    in_code_gain_exponent <= ge;
    in_pitch_sample <= ps;
    in_code_sample <= cs;
    do @(posedge clk); while (in_stall);
    predict_word(c, idx, cv, pg, gm, ge, ps, cs);
  endtask

  task automatic send_coef(logic [3:0] idx, shortint v);
    send_word(ces_pkg::CMD_COEF, idx, v, 16'($urandom), 16'($urandom), 6'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_gains(shortint pg, shortint gm, logic signed [5:0] ge);
    send_word(ces_pkg::CMD_GAINS, 4'($urandom), 16'($urandom), pg, gm, ge,
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_pair(shortint ps, shortint cs);
    send_word(ces_pkg::CMD_PAIR, 4'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 6'($urandom), ps, cs);
  endtask

  task automatic send_unused();
    send_word(CMD_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              6'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic shortint rand_span(int span);
    return shortint'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Stable filter with moderate coefficients, occasionally full-range noise.
  task automatic load_filter(bit wild);
    send_coef(4'd0, wild ? shortint'($urandom) : shortint'(4096));
    for (int i = 1; i <= ces_pkg::ORDER; i++)
      send_coef(4'(i), wild ? shortint'($urandom) : rand_span(1200));
  endtask

  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)
      send_pair(rand_span(9000), rand_span(9000));
    else if (pick < 86)
      send_pair(16'($urandom), 16'($urandom));
    else if (pick < 92)
      send_gains(16'($urandom_range(20000)), rand_span(12000), 6'($urandom_range(4)));
    else if (pick < 95)
      send_gains(16'($urandom), 16'($urandom), 6'($urandom));
    else if (pick < 98)
      send_coef(4'($urandom_range(ces_pkg::ORDER)), rand_span(1500));
    else
      send_unused();
  endtask

  task automatic test_directed();
    load_filter(1'b0);
    send_coef(4'd11, 16'sh7fff);
    send_coef(4'd15, -16'sh8000);
    send_word(CMD_UNUSED, 4'hf, -16'sd1, -16'sd1, -16'sd1, -6'sd1, -16'sd1, -16'sd1);
    send_gains(16'sh7fff, 16'sh7fff, 6'sd31);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(-16'sh8000, -16'sh8000);
    send_gains(-16'sh8000, -16'sh8000, -6'sd32);
    send_pair(-16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, -16'sh8000);
    send_gains(16'sd8000, 16'sd0, 6'sd0);
    send_pair(16'sd1000, 16'sh7fff);
    send_gains(16'sd12000, 16'sd9000, 6'sd2);
    send_pair(16'sd3000, -16'sd2000);
    send_pair(16'sd0, 16'sd0);
  endtask

  task automatic test_ignored_words();
    repeat (3) begin
      send_coef(4'($urandom_range(15, 11)), 16'($urandom));
      send_unused();
    end
  endtask

  task automatic test_random_subframes(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) load_filter($urandom_range(3) == 0);
      send_random_word();
    end
  endtask

  task automatic test_saturating_subframe();
    load_filter(1'b1);
    send_gains(16'sh7fff, 16'sh7fff, 6'sd20);
    while (pair_count != 0) send_pair(16'($urandom), 16'($urandom));
    repeat (ces_pkg::SUB_LEN) send_pair(16'($urandom), 16'($urandom));
    load_filter(1'b0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold = 1'b0;
      end
    join_none
    calm = 1'b1;
    repeat (50) send_pair(rand_span(9000), rand_span(9000));
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= hold || (!calm && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    speech_word_t sw;
    if (rst_n && out_valid && !out_stall) begin
      if (speech_expected.size() == 0) begin
        $display("%0t: unexpected speech word %0d", $time, out_speech_sample);
        errors++;
      end else begin
        sw = speech_expected.pop_front();
        if (out_speech_sample !== sw.speech) begin
          $display("%0t: speech expected %0d actual %0d", $time, sw.speech,
                   out_speech_sample);
          errors++;
        end
        if (out_last !== sw.last) begin
          $display("%0t: last expected %0b actual %0b", $time, sw.last, out_last);
          errors++;
        end
        if (out_rescaled !== sw.resc) begin
          $display("%0t: rescaled expected %0b actual %0b", $time, sw.resc,
                   out_rescaled);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("** celp_excitation_and_synthesis_filter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ces_pkg::NCOEF; i++) coefs[i] = 0;
    for (int i = 0; i < ces_pkg::ORDER; i++) syn_memory[i] = 0;
    pitch_gain_q = 0;
    code_mant_q = 0;
    code_exp_q = 0;
    pair_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ignored_words();
    calm = 1'b1;
    test_random_subframes(30);
    calm = 1'b0;
    test_random_subframes(40);
    test_saturating_subframe();
    test_backpressure();
    test_random_subframes(40);
    while (pair_count != 0) send_pair(rand_span(9000), rand_span(9000));
    in_valid <= 1'b0;
    while (speech_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("** celp_excitation_and_synthesis_filter_core: PASSED **");
    else
      $display("** celp_excitation_and_synthesis_filter_core: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/ces_pkg.sv
hw/rtl/ces_ram.sv
hw/rtl/ces_mac.sv
hw/rtl/celp_excitation_and_synthesis_filter_core.sv
dv/tb_top.sv
